// ===== rtl/sparse_polynomial_mul_add_defines.svh =====
// assertion macros for the sparse polynomial multiply and add block
`ifndef SPARSE_POLYNOMIAL_MUL_ADD_DEFINES_SVH
`define SPARSE_POLYNOMIAL_MUL_ADD_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked at every rising edge out of reset
`define SPM_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SPM_ASSERT_IMPL(name, ante, cons, msg)
`define SPM_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== rtl/spm_pkg.sv =====
// shared types and constants of the sparse polynomial multiply and add block
`default_nettype none

package spm_pkg;

	// field widths
	localparam int CMD_W      = 3;
	localparam int COEF_W     = 16;
	localparam int EXP_W      = 10;
	localparam int OUT_COEF_W = 36;
	localparam int OUT_EXP_W  = 11;
	localparam int TERM_W     = COEF_W + EXP_W;

	// stream data widths, padded to whole bytes
	localparam int IN_TDATA_W  = ((COEF_W + EXP_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_COEF_W + OUT_EXP_W + 7) / 8) * 8;

	// exponent range and product table geometry
	localparam int MAX_EXP   = 1023;
	localparam int TAB_DEPTH = 2 * MAX_EXP + 1;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam logic [TAB_AW-1:0] TAB_TOP = TAB_AW'(TAB_DEPTH - 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR        = 3'd0,
		CMD_LOAD_FIRST   = 3'd1,
		CMD_LOAD_SECOND  = 3'd2,
		CMD_READ_PRODUCT = 3'd3,
		CMD_READ_SUM     = 3'd4
	} spm_cmd_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR_TAB,
		ST_PAIR_MUL,
		ST_PAIR_ACC,
		ST_FIND,
		ST_SUM,
		ST_DONE
	} spm_state_t;

	// one input transfer as seen by the controller
	typedef struct packed {
		logic                     valid;
		logic [CMD_W-1:0]         op;
		logic signed [COEF_W-1:0] coef;
		logic [EXP_W-1:0]         exp;
	} spm_cmd_t;

	// one result term handed to the output register
	typedef struct packed {
		logic                         valid;
		logic signed [OUT_COEF_W-1:0] coef;
		logic [OUT_EXP_W-1:0]         exp;
		logic                         last;
	} spm_res_t;

endpackage

`default_nettype wire

// ===== rtl/spm_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none

module spm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/spm_ctrl.sv =====
// sequencer and datapath around the term stores and the product table
`default_nettype none

module spm_ctrl import spm_pkg::*; #(
	parameter int MAX_TERMS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  spm_cmd_t cmd,
	input  logic     out_free,
	output logic     idle,
	output spm_res_t res
);

	localparam int CW    = $clog2(MAX_TERMS + 1);
	localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int ACC_W = 2 * COEF_W + $clog2(MAX_TERMS);

	spm_state_t state_q, state_d;

	logic [CW-1:0] fcount_q, fcount_d, scount_q, scount_d;
	logic [CW-1:0] sci_q, sci_d, scj_q, scj_d;
	logic [CW-1:0] pi_q, pi_d, pj_q, pj_d;
	logic [CW-1:0] ni_q, ni_d, nj_q, nj_d;
	logic          built_q, built_d;
	logic          ph_q, ph_d;
	logic [TAB_AW-1:0] cursor_q, cursor_d;
	logic [TAB_AW-1:0] clr_q, clr_d;
	logic [TAB_AW-1:0] ptr_q, ptr_d;
	logic              more_q, more_d;
	logic              pend_s1, pend_d;
	logic [TAB_AW-1:0] pend_addr_s1, pend_addr_d;

	// payload registers
	logic [EXP_W-1:0]             flast_q, flast_d, slast_q, slast_d;
	logic [TAB_AW-1:0]            e_s1, e_d;
	logic signed [2*COEF_W-1:0]   prod_s1, prod_d;
	logic signed [OUT_COEF_W-1:0] res_coef_q, res_coef_d;
	logic [OUT_EXP_W-1:0]         res_exp_q, res_exp_d;
	logic                         res_last_q, res_last_d;

	// memory ports
	logic              f_we, s_we;
	logic [TERM_W-1:0] term_wdata, f_rdata, s_rdata;
	logic              t_we;
	logic [TAB_AW-1:0] t_waddr, t_raddr;
	logic [ACC_W-1:0]  t_wdata, t_rdata;

	// term views and merge helpers
	logic signed [COEF_W-1:0]   fc, sc;
	logic [EXP_W-1:0]           fe, se;
	logic                       fa, sb;
	logic signed [COEF_W:0]     pair_sum;
	logic [TAB_AW-1:0]          pair_e;
	logic signed [2*COEF_W-1:0] pair_prod;
	logic                       t_hit, t_cancel;
	logic signed [COEF_W:0]     t_coef;
	logic [EXP_W-1:0]           t_exp;
	logic [CW-1:0]              t_ni, t_nj;
	logic                       tab_nz, hit, miss;
	logic                       load_ok_f, load_ok_s;

	spm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_first (
		.clk   (clk),
		.we    (f_we),
		.waddr (fcount_q[AW-1:0]),
		.wdata (term_wdata),
		.raddr (pi_d[AW-1:0]),
		.rdata (f_rdata)
	);

	spm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_second (
		.clk   (clk),
		.we    (s_we),
		.waddr (scount_q[AW-1:0]),
		.wdata (term_wdata),
		.raddr (pj_d[AW-1:0]),
		.rdata (s_rdata)
	);

	spm_ram #(.WIDTH(ACC_W), .DEPTH(TAB_DEPTH)) u_table (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	assign term_wdata = {cmd.exp, cmd.coef};

	// term stores are read every cycle at the next position, so data matches pi_q / pj_q
	assign fc = f_rdata[COEF_W-1:0];
	assign fe = f_rdata[COEF_W +: EXP_W];
	assign sc = s_rdata[COEF_W-1:0];
	assign se = s_rdata[COEF_W +: EXP_W];
	assign fa = (pi_q < fcount_q);
	assign sb = (pj_q < scount_q);

	assign pair_sum  = (COEF_W + 1)'(fc) + (COEF_W + 1)'(sc);
	assign pair_e    = TAB_AW'(fe) + TAB_AW'(se);
	assign pair_prod = fc * sc;

	assign load_ok_f = (fcount_q < CW'(MAX_TERMS)) && (cmd.coef != '0)
		&& (cmd.exp <= EXP_W'(MAX_EXP)) && ((fcount_q == '0) || (cmd.exp < flast_q));
	assign load_ok_s = (scount_q < CW'(MAX_TERMS)) && (cmd.coef != '0)
		&& (cmd.exp <= EXP_W'(MAX_EXP)) && ((scount_q == '0) || (cmd.exp < slast_q));

	// one merge step of the sum at positions pi_q, pj_q
	always_comb begin
		t_hit    = 1'b0;
		t_cancel = 1'b0;
		t_coef   = '0;
		t_exp    = '0;
		t_ni     = pi_q;
		t_nj     = pj_q;
		priority if (fa && sb && (fe == se)) begin
			t_ni = CW'(pi_q + 1'b1);
			t_nj = CW'(pj_q + 1'b1);
			if (pair_sum == '0) begin
				t_cancel = 1'b1;
			end else begin
				t_hit  = 1'b1;
				t_coef = pair_sum;
				t_exp  = fe;
			end
		end else if (fa && (!sb || (fe > se))) begin
			t_hit  = 1'b1;
			t_coef = (COEF_W + 1)'(fc);
			t_exp  = fe;
			t_ni   = CW'(pi_q + 1'b1);
		end else if (sb) begin
			t_hit  = 1'b1;
			t_coef = (COEF_W + 1)'(sc);
			t_exp  = se;
			t_nj   = CW'(pj_q + 1'b1);
		end else begin
			t_hit = 1'b0;
		end
	end

	// table scan: hit on a nonzero entry, miss once every address has been tried
	assign tab_nz = (t_rdata != '0);
	assign hit    = pend_s1 && tab_nz;
	assign miss   = !pend_s1 && !more_q;

	assign idle = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		fcount_d    = fcount_q;
		scount_d    = scount_q;
		sci_d       = sci_q;
		scj_d       = scj_q;
		pi_d        = pi_q;
		pj_d        = pj_q;
		ni_d        = ni_q;
		nj_d        = nj_q;
		built_d     = built_q;
		ph_d        = ph_q;
		cursor_d    = cursor_q;
		clr_d       = clr_q;
		ptr_d       = ptr_q;
		more_d      = more_q;
		pend_d      = pend_s1;
		pend_addr_d = pend_addr_s1;
		flast_d     = flast_q;
		slast_d     = slast_q;
		e_d         = e_s1;
		prod_d      = prod_s1;
		res_coef_d  = res_coef_q;
		res_exp_d   = res_exp_q;
		res_last_d  = res_last_q;
		f_we        = 1'b0;
		s_we        = 1'b0;
		t_we        = 1'b0;
		t_waddr     = clr_q;
		t_wdata     = '0;
		t_raddr     = ptr_q;
		res.valid   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					unique case (cmd.op)
						CMD_CLEAR: begin
							fcount_d = '0;
							scount_d = '0;
							built_d  = 1'b0;
							cursor_d = TAB_TOP;
							sci_d    = '0;
							scj_d    = '0;
						end
						CMD_LOAD_FIRST: begin
							if (load_ok_f) begin
								f_we     = 1'b1;
								fcount_d = CW'(fcount_q + 1'b1);
								flast_d  = cmd.exp;
								built_d  = 1'b0;
								cursor_d = TAB_TOP;
								sci_d    = '0;
								scj_d    = '0;
							end
						end
						CMD_LOAD_SECOND: begin
							if (load_ok_s) begin
								s_we     = 1'b1;
								scount_d = CW'(scount_q + 1'b1);
								slast_d  = cmd.exp;
								built_d  = 1'b0;
								cursor_d = TAB_TOP;
								sci_d    = '0;
								scj_d    = '0;
							end
						end
						CMD_READ_PRODUCT: begin
							if (built_q) begin
								state_d = ST_FIND;
								ptr_d   = cursor_q;
								more_d  = 1'b1;
								pend_d  = 1'b0;
								ph_d    = 1'b0;
							end else begin
								state_d = ST_CLEAR_TAB;
								clr_d   = TAB_TOP;
							end
						end
						CMD_READ_SUM: begin
							state_d = ST_SUM;
							pi_d    = sci_q;
							pj_d    = scj_q;
							ph_d    = 1'b0;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			// zero the whole table before accumulating
			ST_CLEAR_TAB: begin
				t_we    = 1'b1;
				t_waddr = clr_q;
				t_wdata = '0;
				if (clr_q == '0) begin
					if ((fcount_q != '0) && (scount_q != '0)) begin
						pi_d    = '0;
						pj_d    = '0;
						state_d = ST_PAIR_MUL;
					end else begin
						built_d  = 1'b1;
						cursor_d = TAB_TOP;
						ptr_d    = TAB_TOP;
						more_d   = 1'b1;
						pend_d   = 1'b0;
						ph_d     = 1'b0;
						state_d  = ST_FIND;
					end
				end else begin
					clr_d = clr_q - 1'b1;
				end
			end

			// multiply one term pair and fetch its table entry
			ST_PAIR_MUL: begin
				t_raddr = pair_e;
				e_d     = pair_e;
				prod_d  = pair_prod;
				state_d = ST_PAIR_ACC;
			end

			// accumulate and write back, then step to the next pair
			ST_PAIR_ACC: begin
				t_we    = 1'b1;
				t_waddr = e_s1;
				t_wdata = t_rdata + ACC_W'(prod_s1);
				if (CW'(pj_q + 1'b1) < scount_q) begin
					pj_d    = CW'(pj_q + 1'b1);
					state_d = ST_PAIR_MUL;
				end else if (CW'(pi_q + 1'b1) < fcount_q) begin
					pi_d    = CW'(pi_q + 1'b1);
					pj_d    = '0;
					state_d = ST_PAIR_MUL;
				end else begin
					built_d  = 1'b1;
					cursor_d = TAB_TOP;
					ptr_d    = TAB_TOP;
					more_d   = 1'b1;
					pend_d   = 1'b0;
					ph_d     = 1'b0;
					state_d  = ST_FIND;
				end
			end

			// downward scan, one table read issued per cycle
			ST_FIND: begin
				if (more_q) begin
					pend_d      = 1'b1;
					pend_addr_d = ptr_q;
					if (ptr_q == '0) begin
						more_d = 1'b0;
					end else begin
						ptr_d = ptr_q - 1'b1;
					end
				end else begin
					pend_d = 1'b0;
				end
				if (!ph_q) begin
					if (hit) begin
						res_coef_d = OUT_COEF_W'(signed'(t_rdata));
						res_exp_d  = OUT_EXP_W'(pend_addr_s1);
						if (pend_addr_s1 == '0) begin
							res_last_d = 1'b1;
							cursor_d   = pend_addr_s1;
							state_d    = ST_DONE;
						end else begin
							ph_d   = 1'b1;
							ptr_d  = pend_addr_s1 - 1'b1;
							more_d = 1'b1;
							pend_d = 1'b0;
						end
					end else if (miss) begin
						res_coef_d = '0;
						res_exp_d  = '0;
						res_last_d = 1'b1;
						state_d    = ST_DONE;
					end
				end else begin
					if (hit) begin
						cursor_d   = pend_addr_s1;
						res_last_d = 1'b0;
						state_d    = ST_DONE;
					end else if (miss) begin
						cursor_d   = res_exp_q[TAB_AW-1:0];
						res_last_d = 1'b1;
						state_d    = ST_DONE;
					end
				end
			end

			// merge walk: first find the term, then look for one after it
			ST_SUM: begin
				if (t_cancel) begin
					pi_d = t_ni;
					pj_d = t_nj;
				end else if (t_hit) begin
					if (!ph_q) begin
						res_coef_d = OUT_COEF_W'(t_coef);
						res_exp_d  = OUT_EXP_W'(t_exp);
						ni_d       = t_ni;
						nj_d       = t_nj;
						pi_d       = t_ni;
						pj_d       = t_nj;
						ph_d       = 1'b1;
					end else begin
						sci_d      = ni_q;
						scj_d      = nj_q;
						res_last_d = 1'b0;
						state_d    = ST_DONE;
					end
				end else begin
					if (!ph_q) begin
						res_coef_d = '0;
						res_exp_d  = '0;
					end
					res_last_d = 1'b1;
					state_d    = ST_DONE;
				end
			end

			ST_DONE: begin
				res.valid = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res.coef = res_coef_q;
	assign res.exp  = res_exp_q;
	assign res.last = res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fcount_q     <= '0;
			scount_q     <= '0;
			sci_q        <= '0;
			scj_q        <= '0;
			pi_q         <= '0;
			pj_q         <= '0;
			ni_q         <= '0;
			nj_q         <= '0;
			built_q      <= 1'b0;
			ph_q         <= 1'b0;
			cursor_q     <= TAB_TOP;
			clr_q        <= '0;
			ptr_q        <= '0;
			more_q       <= 1'b0;
			pend_s1      <= 1'b0;
			pend_addr_s1 <= '0;
		end else begin
			state_q      <= state_d;
			fcount_q     <= fcount_d;
			scount_q     <= scount_d;
			sci_q        <= sci_d;
			scj_q        <= scj_d;
			pi_q         <= pi_d;
			pj_q         <= pj_d;
			ni_q         <= ni_d;
			nj_q         <= nj_d;
			built_q      <= built_d;
			ph_q         <= ph_d;
			cursor_q     <= cursor_d;
			clr_q        <= clr_d;
			ptr_q        <= ptr_d;
			more_q       <= more_d;
			pend_s1      <= pend_d;
			pend_addr_s1 <= pend_addr_d;
		end
	end

	always_ff @(posedge clk) begin
		flast_q    <= flast_d;
		slast_q    <= slast_d;
		e_s1       <= e_d;
		prod_s1    <= prod_d;
		res_coef_q <= res_coef_d;
		res_exp_q  <= res_exp_d;
		res_last_q <= res_last_d;
	end

endmodule

`default_nettype wire

// ===== rtl/sparse_polynomial_mul_add.sv =====
// top level of the sparse polynomial multiply and add block
// Two sparse polynomials of up to MAX_TERMS terms each are loaded one term per
// transfer (nonzero coefficient, strictly descending exponent; other loads are
// dropped). Read commands return one term of the product or of the sum per
// transfer, highest exponent first, like terms merged and zero terms dropped;
// an empty result reads as coefficient 0, exponent 0 with tlast set, and
// reading past the end repeats the final term. Clear and load give no output.
// A sum read walks the two term stores in merge steps (each cancelling pair
// of like terms costs one more step), then hands the term to the output
// register. The product lives in a 2047-entry accumulator RAM: the first
// product read after reset, clear or a load first runs a clearing pass over
// the RAM, one entry per cycle, then accumulates every term pair through one
// multiplier and a read-modify-write on the RAM port (ST_PAIR_MUL, then
// ST_PAIR_ACC); every product read then scans the RAM one entry per cycle
// from the current term down to the next nonzero one. Only one command is
// worked on at a time; a finished term waits in the output register while
// the next command is accepted.
`default_nettype none
`include "sparse_polynomial_mul_add_defines.svh"

module sparse_polynomial_mul_add import spm_pkg::*; #(
	parameter int MAX_TERMS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// command stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // term_coefficient, term_exponent, zero pad
	input  logic [CMD_W-1:0]       s_axis_tuser,   // command
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_coefficient, out_exponent, zero pad
	output logic                   m_axis_tlast    // is_last
);

	spm_cmd_t cmd;
	spm_res_t ctrl_res;
	logic     ctrl_idle;
	logic     out_free;

	// output register
	logic                         out_valid_q;
	logic signed [OUT_COEF_W-1:0] out_coef_q;
	logic [OUT_EXP_W-1:0]         out_exp_q;
	logic                         out_last_q;

	// the controller only looks at a command while idle, so valid here is the transfer
	assign cmd.valid = s_axis_tvalid && s_axis_tready;
	assign cmd.op    = s_axis_tuser;
	assign cmd.coef  = s_axis_tdata[COEF_W-1:0];
	assign cmd.exp   = s_axis_tdata[COEF_W +: EXP_W];

	assign s_axis_tready = ctrl_idle;

	// room for a new term when the register is empty or drains this cycle
	assign out_free = !out_valid_q || m_axis_tready;

	spm_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.out_free (out_free),
		.idle     (ctrl_idle),
		.res      (ctrl_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_res.valid) begin
			out_coef_q <= ctrl_res.coef;
			out_exp_q  <= ctrl_res.exp;
			out_last_q <= ctrl_res.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_COEF_W - OUT_EXP_W){1'b0}}, out_exp_q, out_coef_q};
	assign m_axis_tlast  = out_last_q;

	// a term is only handed over when the output register can take it
	`SPM_ASSERT_IMPL(a_res_slot_free, ctrl_res.valid, !out_valid_q || m_axis_tready, "result handed over while output register is full")

	// clear and load transfers never produce a result
	`SPM_ASSERT_NEXT(a_load_no_result, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_CLEAR || s_axis_tuser == CMD_LOAD_FIRST || s_axis_tuser == CMD_LOAD_SECOND), !ctrl_res.valid, "result produced by a clear or load")

	// a product read always leaves the controller busy once it is accepted
	`SPM_ASSERT_NEXT(a_read_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_READ_PRODUCT, !s_axis_tready, "product read finished without work")

endmodule

`default_nettype wire
